@@ rtl/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VALUE_W = 32;
    localparam int RADIX_W = 5;
    localparam int QUO_W   = 31;   // magnitude bits of a non-negative value
    localparam int REM_W   = 4;    // one digit, base 16 at most
    localparam int CHAR_W  = 8;
    localparam int STAT_W  = 2;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_RADIX = 2'd1;
    localparam logic [STAT_W-1:0] ST_NEGATIVE  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [REM_W-1:0]  DEC_LIMIT = 4'd10;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_LIMIT)
        begin
            ch = CHAR_ZERO + {{(CHAR_W-REM_W){1'b0}}, d};
        end
        else
        begin
            ch = CHAR_A + {{(CHAR_W-REM_W){1'b0}}, d - DEC_LIMIT};
        end
        return ch;
    endfunction

endpackage

@@ rtl/rdc_divider.sv @@
// ----------------------------------------------------------------------------
// rdc_divider
// Restoring bit-serial divider: 31-bit dividend by a base of 2..16, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdc_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rdc_pkg::QUO_W-1:0]   dividend,
    input  logic [rdc_pkg::RADIX_W-1:0] divisor,
    output logic [rdc_pkg::QUO_W-1:0]   quotient,
    output logic [rdc_pkg::REM_W-1:0]   remainder,
    output rdc_pkg::div_stat_t          stat
);
    import rdc_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [RADIX_W-1:0] trial;
    logic               fits;

    // shift in the next dividend bit and try one subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        fits  = (trial >= divisor);
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[QUO_W-2:0], fits};
            rem_next = fits ? REM_W'(trial - divisor) : trial[REM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ rtl/radix_digit_converter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a non-negative 32-bit number to ASCII digits of base 2..16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word: value and radix.
//   Output channel (out_valid / out_stall) carries one character per word,
//   most significant digit first, with last_digit on the final one.
//   A base outside 2..16 gives one word with status 1, a negative value one
//   word with status 2; both carry digit_char zero and last_digit set.
//   A zero value gives the single character '0'.
// Sequence:
//   Error and zero words appear in the cycle after acceptance. Otherwise each
//   digit takes one pass of the shared bit-serial divider (31 quotient bits
//   plus start and hand-back); once all digits are stored, each is read from
//   the digit store and then emitted. The block holds in_stall high until the
//   last character is in the output register. Value and base are latched at
//   acceptance, so the input ports are free to change while a conversion runs.
// Reset:
//   rst_n clears the sequencer and the output valid; the digit store is not
//   cleared, since every entry is written before it is read.
// Backpressure:
//   While out_stall is high the output word holds and the sequencer waits.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
    parameter int DIGIT_STORE_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rdc_pkg::VALUE_W-1:0] value,
    input  logic [rdc_pkg::RADIX_W-1:0]        radix,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rdc_pkg::CHAR_W-1:0]         digit_char,
    output logic                              last_digit,
    output logic [rdc_pkg::STAT_W-1:0]         status
);
    import rdc_pkg::*;

    localparam int AW = $clog2(DIGIT_STORE_DEPTH);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_DIV      = 2'd1;
    localparam logic [1:0] S_EMIT_RD  = 2'd2;
    localparam logic [1:0] S_EMIT_OUT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              start_reg, start_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [REM_W-1:0]  rd_reg;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic [REM_W-1:0]  store_mem [DIGIT_STORE_DEPTH];
    logic              store_we;

    logic [QUO_W-1:0]  div_quo;
    logic [REM_W-1:0]  div_rem;
    div_stat_t         div_stat;

    logic              slot_free;
    logic              in_accept;
    logic              radix_ok;

    rdc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (quo_reg),
        .divisor   (radix_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // output register frees when empty or being taken this cycle
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !slot_free;
    assign in_accept = in_valid && !in_stall;
    assign store_we  = (state_reg == S_DIV) && div_stat.done;

    always_comb
    begin
        radix_ok = radix inside {[MIN_RADIX:MAX_RADIX]};
    end

    // sequencer: answer error and zero words directly, else divide until the
    // quotient runs out, then emit digits from the top of the store down
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        start_next     = 1'b0;
        quo_next       = quo_reg;
        radix_next     = radix_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        stat_next      = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    char_next      = '0;
                    if (!radix_ok)
                    begin
                        stat_next = ST_BAD_RADIX;
                    end
                    else if (value[VALUE_W-1])
                    begin
                        stat_next = ST_NEGATIVE;
                    end
                    else if (value == '0)
                    begin
                        stat_next = ST_OK;
                        char_next = CHAR_ZERO;
                    end
                    else
                    begin
                        // no word yet: hold the base and start dividing
                        out_valid_next = 1'b0;
                        quo_next       = value[QUO_W-1:0];
                        radix_next     = radix;
                        ptr_next       = '0;
                        start_next     = 1'b1;
                        state_next     = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    quo_next = div_quo;
                    if (div_quo == '0)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        // at most 31 digits, so the pointer stays inside the store
                        ptr_next   = ptr_reg + 1'b1;
                        start_next = 1'b1;
                    end
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_to_ascii(rd_reg);
                    stat_next      = ST_OK;
                    last_next      = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            start_reg     <= 1'b0;
            quo_reg       <= '0;
            radix_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            start_reg     <= start_next;
            quo_reg       <= quo_next;
            radix_reg     <= radix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        stat_reg <= stat_next;
    end

    // digit store: write one remainder per division, read one per emitted word
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[ptr_reg] <= div_rem;
        end
        rd_reg <= store_mem[ptr_reg];
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;
    assign status     = stat_reg;

    // the divider runs only while the sequencer waits on it
    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside division phase");

    // an error word is a lone, blank final word
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (last_digit && (digit_char == '0)))
        else $error("error word without last flag or with a character");

    // a division pass finishes only when a start began it
    a_div_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> $past(start_reg, QUO_W + 1))
        else $error("divider done without matching start");

    // the final digit leaves the sequencer idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT_OUT) && slot_free && (ptr_reg == '0))
            |=> (state_reg == S_IDLE) && out_valid && last_digit)
        else $error("last digit did not close the conversion");

endmodule

@@ tb/radix_digit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digit_checker
// Watches both channels of the radix digit converter, predicts the character
// stream of every accepted word and compares it with what the block emits.
// ----------------------------------------------------------------------------
module radix_digit_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [rdc_pkg::VALUE_W-1:0]  value,
    input  logic [rdc_pkg::RADIX_W-1:0]         radix,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [rdc_pkg::CHAR_W-1:0]          digit_char,
    input  logic                                last_digit,
    input  logic [rdc_pkg::STAT_W-1:0]          status,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  words_in,
    output int                                  chars_out
);
    import rdc_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [STAT_W-1:0] st;
    } char_word_t;

    char_word_t expected_chars[$];

    // Queue the characters one word turns into, most significant first.
    function automatic void predict_digits(input logic signed [VALUE_W-1:0] num,
                                           input logic [RADIX_W-1:0] base);
        logic [REM_W-1:0] digits [0:31];
        logic [QUO_W-1:0] quo;
        int               n;
        int               i;
        char_word_t       w;
        if (base < MIN_RADIX || base > MAX_RADIX)
        begin
            w = '{ch: '0, last: 1'b1, st: ST_BAD_RADIX};
            expected_chars.push_back(w);
        end
        else if (num < 0)
        begin
            w = '{ch: '0, last: 1'b1, st: ST_NEGATIVE};
            expected_chars.push_back(w);
        end
        else if (num == 0)
        begin
            w = '{ch: CHAR_ZERO, last: 1'b1, st: ST_OK};
            expected_chars.push_back(w);
        end
        else
        begin
            quo = num[QUO_W-1:0];
            n = 0;
            while (quo != 0 && n < 32)
            begin
                digits[n] = REM_W'(quo % base);
                quo = quo / base;
                n++;
            end
            for (i = n - 1; i >= 0; i--)
            begin
                w.ch = (digits[i] < DEC_LIMIT) ? CHAR_ZERO + digits[i]
                                               : CHAR_A + (digits[i] - DEC_LIMIT);
                w.last = (i == 0);
                w.st = ST_OK;
                expected_chars.push_back(w);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        char_word_t exp_w;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
            words_in <= 0;
            chars_out <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_digits(value, radix);
                words_in <= words_in + 1;
            end
            if (out_valid && !out_stall)
            begin
                chars_out <= chars_out + 1;
                if (expected_chars.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    $display("%0t: expected no word, actual char %h last %b status %0d",
                             $time, digit_char, last_digit, status);
                end
                else
                begin
                    exp_w = expected_chars.pop_front();
                    if (exp_w != {digit_char, last_digit, status})
                    begin
                        fail_count <= fail_count + 1;
                        if (exp_w.ch != digit_char)
                            $display("%0t: digit_char expected %h actual %h",
                                     $time, exp_w.ch, digit_char);
                        if (exp_w.last != last_digit)
                            $display("%0t: last_digit expected %b actual %b",
                                     $time, exp_w.last, last_digit);
                        if (exp_w.st != status)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, exp_w.st, status);
                    end
                end
            end
            pending <= expected_chars.size();
        end
    end

endmodule

@@ tb/tb_radix_digit_converter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_digit_converter
// Drives numbers and bases into the radix digit converter under several
// mixes of sender gaps and receiver stalls, including one long output
// hold-off, and reports the verdict of the checker that runs beside it.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter;
    import rdc_pkg::*;

    // The limit is meant to cover even 320 words of 31 digits each with heavy
    // stalls, with ample room to spare.
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_WORDS = 320;
    localparam int MIX_STRETCH  = 40;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 1200;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mix_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] value;
    logic [RADIX_W-1:0]        radix;
    logic                      out_valid;
    logic                      out_stall;
    logic [CHAR_W-1:0]         digit_char;
    logic                      last_digit;
    logic [STAT_W-1:0]         status;

    int        fail_count;
    int        pending;
    int        words_in;
    int        chars_out;
    int        cycles;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_req;

    radix_digit_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .radix      (radix),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit),
        .status     (status)
    );

    radix_digit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .radix      (radix),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending),
        .words_in   (words_in),
        .chars_out  (chars_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles and give up if the block hangs.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d characters still due", cycles, pending);
                $display("** radix_digit_converter: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: stall at random per the current mix, and serve one long
    // hold-off on request so the block backs up into its input channel.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Pick the gap and stall rates for both sides.
    task automatic set_idle_mix(input idle_mix_t mix);
        case (mix)
            IDLE_SENDER:
            begin
                send_idle_pct = 67;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 67;
            end
            IDLE_BOTH:
            begin
                send_idle_pct = 33;
                recv_stall_pct = 33;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Offer one word from a falling edge and hold it until accepted. Return at
    // the falling edge after acceptance with valid still high, so the next
    // call makes the only assignment in that step.
    task automatic send_word(input logic signed [VALUE_W-1:0] v,
                             input logic [RADIX_W-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        radix <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly well-formed conversions with a spread of digit counts; the rest
    // are zeros, negative numbers and bases out of range.
    task automatic send_random_word();
        int                        roll;
        logic signed [VALUE_W-1:0] v;
        logic [RADIX_W-1:0]        r;
        roll = $urandom_range(0, 99);
        if (roll < 72)
        begin
            r = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
            v = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 30);
        end
        else if (roll < 76)
        begin
            r = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
            v = '0;
        end
        else if (roll < 88)
        begin
            r = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
            v = $urandom | 32'h8000_0000;
        end
        else
        begin
            r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(17, 31))
                                     : RADIX_W'($urandom_range(0, 1));
            v = $urandom;
        end
        send_word(v, r);
    endtask

    initial
    begin
        int k;
        int b;
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        radix = '0;
        hold_req = 1'b0;
        set_idle_mix(IDLE_NONE);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero, widest and narrowest outputs, both error kinds and
        // the rule that a bad base wins over a negative number.
        send_word(0, 5'd10);
        send_word(32'sh7FFF_FFFF, 5'd2);
        send_word(32'sh7FFF_FFFF, 5'd16);
        send_word(1, 5'd2);
        send_word(32'sh8000_0000, 5'd10);
        send_word(-1, 5'd31);
        send_word(12345, 5'd0);
        send_word(12345, 5'd1);
        send_word(12345, 5'd17);
        // Walk the remaining bases so every digit letter can show up.
        for (b = 3; b <= 15; b++)
            send_word(32'sh7FFF_FFFF - b, RADIX_W'(b));

        // Random words in stretches, cycling through the idle mixes; request
        // the long hold-off partway through a stretch without idling.
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k % MIX_STRETCH == 0)
                set_idle_mix(idle_mix_t'((k / MIX_STRETCH) % 4));
            if (k == 20)
                hold_req = 1'b1;
            send_random_word();
        end
        in_valid <= 1'b0;

        // Drain: wait for every predicted character, then watch for strays.
        set_idle_mix(IDLE_NONE);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d words into %0d characters in %0d cycles,", words_in,
                 chars_out, cycles);
        $display("covering all bases, zero, both error kinds, four idle mixes and a hold-off.");
        if (fail_count == 0)
            $display("** radix_digit_converter: PASSED **");
        else
            $display("** radix_digit_converter: FAILED **");
        $finish;
    end

endmodule
